### design/button_debounce_long_press_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the button debounce and long-press block
// Shared helpers for the concurrent checks that watch the top-level ports.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_TOP_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_TOP_DEFINES_SVH

// Check that a condition holds at every rising edge outside reset.
`define BDLP_ASSERT(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("bdlp check failed");

// Check that a trigger implies a consequence in the cycle after it.
`define BDLP_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cons)) \
    else $error("bdlp check failed");

`endif

### design/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants shared by the button debounce and long-press modules.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  // Fixed field and register widths.
  localparam int FieldWidth    = 5;
  localparam int DebounceWidth = 8;
  localparam int HoldWidth     = 16;
  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 16;

  // Default number of buttons in the bank.
  localparam int ButtonCountDefault = 5;

  // Register indexes on the configuration port.
  localparam logic [CfgIndexWidth-1:0] RegDebounceTicks  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegLongPressTicks = 2'd1;

  // Register reset values.
  localparam logic [DebounceWidth-1:0] DebounceTicksReset  = 8'd20;
  localparam logic [HoldWidth-1:0]     LongPressTicksReset = 16'd1000;

  // Saturation limit of the hold timer.
  localparam logic [HoldWidth-1:0] HoldMax = {HoldWidth{1'b1}};

  // What one lane reports for one tick.
  typedef struct packed {
    logic short_press;
    logic long_press;
    logic held;
  } lane_result_t;

endpackage

### design/bdlp_lane.sv
// ----------------------------------------------------------------------------
// bdlp_lane
// Debounce and press timing for one button; state advances on each accepted tick.
// ----------------------------------------------------------------------------
module bdlp_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                tick_i,
  input  logic                                level_i,
  input  logic [bdlp_pkg::DebounceWidth-1:0]  debounce_ticks_i,
  input  logic [bdlp_pkg::HoldWidth-1:0]      long_press_ticks_i,
  output bdlp_pkg::lane_result_t              result_o
);

  logic                               prev_q, prev_d;
  logic                               stable_q, stable_d;
  logic                               long_rep_q, long_rep_d;
  logic [bdlp_pkg::DebounceWidth-1:0] equal_q, equal_d;
  logic [bdlp_pkg::HoldWidth-1:0]     hold_q, hold_d;

  logic                               change;
  logic                               release_evt;
  logic [bdlp_pkg::HoldWidth-1:0]     hold_mid;
  logic                               long_rep_mid;
  logic                               long_evt;

  // Next state and this tick's report.
  always_comb begin
    // Run length of equal samples, saturating at the threshold.
    if (level_i == prev_q) begin
      equal_d = (equal_q < debounce_ticks_i) ? 8'(equal_q + 8'd1) : equal_q;
    end else begin
      equal_d = '0;
    end
    prev_d = level_i;

    // Accepted level change; a press restarts the hold timer.
    change       = (equal_d >= debounce_ticks_i) && (level_i != stable_q);
    release_evt  = change && level_i;
    hold_mid     = (change && !level_i) ? '0 : hold_q;
    long_rep_mid = release_evt ? 1'b0 : long_rep_q;
    stable_d     = change ? level_i : stable_q;

    // Timing while the debounced level is pressed.
    hold_d     = hold_mid;
    long_evt   = 1'b0;
    long_rep_d = long_rep_mid;
    if (!stable_d) begin
      if (hold_mid != bdlp_pkg::HoldMax) begin
        hold_d = hold_mid + 16'd1;
      end
      long_evt   = (hold_d >= long_press_ticks_i) && !long_rep_mid;
      long_rep_d = long_rep_mid | long_evt;
    end

    result_o.short_press = release_evt && (hold_q < long_press_ticks_i);
    result_o.long_press  = long_evt;
    result_o.held        = !stable_d;
  end

  // Control state of the lane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b1;
      stable_q   <= 1'b1;
      long_rep_q <= 1'b0;
      equal_q    <= '0;
      hold_q     <= '0;
    end else if (tick_i) begin
      prev_q     <= prev_d;
      stable_q   <= stable_d;
      long_rep_q <= long_rep_d;
      equal_q    <= equal_d;
      hold_q     <= hold_d;
    end
  end

endmodule

### design/bdlp_merge.sv
// ----------------------------------------------------------------------------
// bdlp_merge
// Packs the lane reports into masks and holds them in a two-entry output queue.
// ----------------------------------------------------------------------------
module bdlp_merge #(
  parameter int LaneCount = bdlp_pkg::ButtonCountDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push_i,
  input  bdlp_pkg::lane_result_t             results_i [LaneCount],
  output logic                               full_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bdlp_pkg::FieldWidth-1:0]    short_press_mask_o,
  output logic [bdlp_pkg::FieldWidth-1:0]    long_press_mask_o,
  output logic [bdlp_pkg::FieldWidth-1:0]    held_mask_o
);

  typedef struct packed {
    logic [bdlp_pkg::FieldWidth-1:0] short_mask;
    logic [bdlp_pkg::FieldWidth-1:0] long_mask;
    logic [bdlp_pkg::FieldWidth-1:0] held_mask;
  } masks_t;

  masks_t     merged;
  masks_t     head_q, head_d;
  masks_t     tail_q, tail_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  // Combine the lanes; bits without a lane stay clear.
  always_comb begin
    merged = '0;
    for (int i = 0; i < LaneCount; i++) begin
      merged.short_mask[i] = results_i[i].short_press;
      merged.long_mask[i]  = results_i[i].long_press;
      merged.held_mask[i]  = results_i[i].held;
    end
  end

  assign pop = out_valid_o && !out_stall_i;

  // Queue update: the head is what the output shows.
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    case ({push_i, pop})
      2'b10: begin
        if (count_q == 2'd0) begin
          head_d = merged;
        end else begin
          tail_d = merged;
        end
        count_d = count_q + 2'd1;
      end
      2'b01: begin
        head_d  = tail_q;
        count_d = count_q - 2'd1;
      end
      2'b11: begin
        if (count_q == 2'd1) begin
          head_d = merged;
        end else begin
          head_d = tail_q;
          tail_d = merged;
        end
      end
      default: begin
      end
    endcase
  end

  // Occupancy count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Payload entries.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign full_o             = (count_q == 2'd2);
  assign out_valid_o        = (count_q != 2'd0);
  assign short_press_mask_o = head_q.short_mask;
  assign long_press_mask_o  = head_q.long_mask;
  assign held_mask_o        = head_q.held_mask;

endmodule

### design/button_debounce_long_press_top.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_top
// Debounced button bank with short and long press reports, one lane per button.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction is one sampling tick carrying raw_levels_i, one
//   active-low pin level per button. Every accepted tick yields exactly one
//   output transaction with the short-press, long-press and held masks.
//   The input is taken when in_valid_i is high and in_stall_o is low; the
//   output is taken when out_valid_o is high and out_stall_i is low.
//   All buttons are updated in parallel lanes in the accept cycle, so one
//   tick is accepted per cycle while in_stall_o is low; its result is registered.
//   Results wait in a two-entry output queue: while the receiver stalls, one
//   more tick is still accepted, after which in_stall_o rises.
//   Thresholds are written through the configuration port (index 0 for the
//   debounce count, 1 for the long-press count); cfg_ready_o is always high
//   and writes to other indexes are ignored. Write them only while idle.
//   Reset clears the queue, marks every button released and restores the
//   default thresholds of 20 and 1000 ticks.
// ----------------------------------------------------------------------------
module button_debounce_long_press_top #(
  parameter int ButtonCount = bdlp_pkg::ButtonCountDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bdlp_pkg::FieldWidth-1:0]     raw_levels_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bdlp_pkg::FieldWidth-1:0]     short_press_mask_o,
  output logic [bdlp_pkg::FieldWidth-1:0]     long_press_mask_o,
  output logic [bdlp_pkg::FieldWidth-1:0]     held_mask_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bdlp_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [bdlp_pkg::CfgDataWidth-1:0]   cfg_data_i
);

  // Buttons beyond the field width cannot show up in any mask.
  localparam int LaneCount =
    (ButtonCount < bdlp_pkg::FieldWidth) ? ButtonCount : bdlp_pkg::FieldWidth;

  logic [bdlp_pkg::DebounceWidth-1:0] debounce_ticks_q;
  logic [bdlp_pkg::HoldWidth-1:0]     long_press_ticks_q;
  logic                               tick;
  logic                               full;
  bdlp_pkg::lane_result_t             results [LaneCount];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign tick        = in_valid_i && !full;

  // Threshold registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q   <= bdlp_pkg::DebounceTicksReset;
      long_press_ticks_q <= bdlp_pkg::LongPressTicksReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == bdlp_pkg::RegDebounceTicks) begin
        debounce_ticks_q <= cfg_data_i[bdlp_pkg::DebounceWidth-1:0];
      end
      if (cfg_index_i == bdlp_pkg::RegLongPressTicks) begin
        long_press_ticks_q <= cfg_data_i[bdlp_pkg::HoldWidth-1:0];
      end
    end
  end

  // One lane per button.
  for (genvar g = 0; g < LaneCount; g++) begin : gen_lane
    bdlp_lane u_lane (
      .clk_i              (clk_i),
      .rst_ni             (rst_ni),
      .tick_i             (tick),
      .level_i            (raw_levels_i[g]),
      .debounce_ticks_i   (debounce_ticks_q),
      .long_press_ticks_i (long_press_ticks_q),
      .result_o           (results[g])
    );
  end

  // Mask assembly and output queue.
  bdlp_merge #(
    .LaneCount (LaneCount)
  ) u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push_i             (tick),
    .results_i          (results),
    .full_o             (full),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .short_press_mask_o (short_press_mask_o),
    .long_press_mask_o  (long_press_mask_o),
    .held_mask_o        (held_mask_o)
  );

endmodule

### design/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// Port-level checks of the button debounce block, bound to the top level.
// ----------------------------------------------------------------------------
`include "button_debounce_long_press_top_defines.svh"

module bdlp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [bdlp_pkg::FieldWidth-1:0]     short_press_mask_o,
  input logic [bdlp_pkg::FieldWidth-1:0]     long_press_mask_o,
  input logic [bdlp_pkg::FieldWidth-1:0]     held_mask_o
);

  // A released button is no longer held on the tick of its short press.
  `BDLP_ASSERT(a_short_not_held, clk_i, rst_ni,
    !out_valid_o || ((short_press_mask_o & held_mask_o) == '0))

  // A long press is only reported for a button that is held.
  `BDLP_ASSERT(a_long_is_held, clk_i, rst_ni,
    !out_valid_o || ((long_press_mask_o & ~held_mask_o) == '0))

  // A stalled output transaction holds its payload.
  `BDLP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(short_press_mask_o) && $stable(long_press_mask_o)
    && $stable(held_mask_o))

  // An accepted tick always leaves a result waiting on the next cycle.
  `BDLP_ASSERT_NEXT(a_tick_gives_result, clk_i, rst_ni, in_valid_i && !in_stall_o,
    out_valid_o)

endmodule

bind button_debounce_long_press_top bdlp_checker u_bdlp_checker (.*);
